// ----- hw/rtl/conv5_pkg.sv -----
package conv5_pkg;

   localparam int KSIZE  = 5;
   localparam int HALF   = 2;
   localparam int TAPS   = KSIZE * KSIZE;
   localparam int PIX_W  = 8;
   localparam int COEF_W = 8;
   localparam int DIM_W  = 11;
   // one line-store word holds the four rows above the current pixel
   localparam int LINE_W = (KSIZE - 1) * PIX_W;
   localparam int PROD_W = COEF_W + PIX_W + 1;
   localparam int ROW_W  = PROD_W + 3;
   localparam int SUM_W  = 21;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_A     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_B     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_C     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_D     = 3'd5;

   // result queue; stages between step launch and queue write, launch included
   localparam int OUTQ_DEPTH = 8;
   localparam int IN_FLIGHT  = 6;
   localparam int QAW        = $clog2(OUTQ_DEPTH);
   localparam int QCW        = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic             valid;
      logic             emit;
      logic             last;
      logic [PIX_W-1:0] px;
      logic [KSIZE-1:0] row_ok;
      logic [KSIZE-1:0] col_ok;
   } step_type;

   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic [KSIZE-1:0]           row_ok;
      logic [KSIZE-1:0]           col_ok;
      logic [TAPS-1:0][PIX_W-1:0] px;
   } win_type;

endpackage

// ----- hw/rtl/conv5_ram.sv -----
module conv5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/conv5_ctrl.sv -----
module conv5_ctrl
   import conv5_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [PIX_W-1:0]              req_pixel,
   input  logic                          req_flush,
   input  logic                          room,
   input  logic [DIM_W-1:0]              frame_width,
   input  logic [DIM_W-1:0]              frame_height,
   output logic                          rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   output step_type                      step_out,
   output logic [$clog2(MAX_WIDTH)-1:0]  step_col
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CAW = $clog2(MAX_WIDTH);
   localparam int LW  = $clog2(2 * MAX_WIDTH + 3);
   localparam int XW  = WW + 1;
   localparam int RW  = DIM_W + 1;

   logic             busy_ff, busy_in;
   logic             in_done_ff, in_done_in;
   logic [WW-1:0]    geo_w_ff, geo_w_in;
   logic [DIM_W-1:0] geo_h_ff, geo_h_in;
   logic [CAW-1:0]   col_ff, col_in;
   logic [DIM_W-1:0] in_row_ff, in_row_in;
   logic [LW-1:0]    lag_ff, lag_in;
   logic [DIM_W-1:0] out_row_ff, out_row_in;
   logic [CAW-1:0]   out_col_ff, out_col_in;
   step_type         step_ff, step_in;
   logic [CAW-1:0]   step_col_ff;

   logic [WW-1:0]    w_cfg, gw;
   logic [DIM_W-1:0] h_cfg, gh;
   logic [LW-1:0]    target;
   logic             aligned, col_last, out_col_last, out_row_last, in_row_last;
   logic             pix_req, drain, fill, step, emit, frame_end;
   logic [KSIZE-1:0] row_ok, col_ok;

   always_comb begin
      if (frame_width == '0) begin
         w_cfg = WW'(1);
      end else if (32'(frame_width) > MAX_WIDTH) begin
         w_cfg = WW'(MAX_WIDTH);
      end else begin
         w_cfg = WW'(frame_width);
      end
      h_cfg = (frame_height == '0) ? DIM_W'(1) : frame_height;
   end

   // geometry is taken from the registers on the first pixel of a frame
   assign gw = busy_ff ? geo_w_ff : w_cfg;
   assign gh = busy_ff ? geo_h_ff : h_cfg;

   // output for a position is due once the pixel two rows and two columns on is in
   assign target       = (LW'(gw) << 1) + LW'(2);
   assign aligned      = (lag_ff == target);
   assign col_last     = (WW'(col_ff) == gw - WW'(1));
   assign out_col_last = (WW'(out_col_ff) == gw - WW'(1));
   assign out_row_last = (out_row_ff == gh - DIM_W'(1));
   assign in_row_last  = (in_row_ff == gh - DIM_W'(1));

   assign pix_req   = req_valid && !req_flush && !in_done_ff;
   assign drain     = req_valid && req_flush && busy_ff && in_done_ff;
   // a drain tick that is not yet due holds the transfer and steps an empty column
   assign fill      = drain && !aligned;
   assign req_ready = room && !fill;
   assign step      = room && (pix_req || drain);
   assign emit      = step && aligned;
   assign frame_end = emit && out_row_last && out_col_last;

   always_comb begin
      for (int i = 0; i < KSIZE; i++) begin
         if (i < HALF) begin
            row_ok[i] = (out_row_ff >= DIM_W'(HALF - i));
            col_ok[i] = (out_col_ff >= CAW'(HALF - i));
         end else begin
            row_ok[i] = (RW'(out_row_ff) + RW'(i - HALF) < RW'(gh));
            col_ok[i] = (XW'(out_col_ff) + XW'(i - HALF) < XW'(gw));
         end
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      in_done_in = in_done_ff;
      geo_w_in   = geo_w_ff;
      geo_h_in   = geo_h_ff;
      col_in     = col_ff;
      in_row_in  = in_row_ff;
      lag_in     = lag_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (step) begin
         if (!busy_ff) begin
            busy_in  = 1'b1;
            geo_w_in = w_cfg;
            geo_h_in = h_cfg;
         end
         col_in = col_last ? '0 : col_ff + CAW'(1);
         if (pix_req && col_last) begin
            in_row_in = in_row_ff + DIM_W'(1);
            if (in_row_last) begin
               in_done_in = 1'b1;
            end
         end
         if (emit) begin
            if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + DIM_W'(1);
            end else begin
               out_col_in = out_col_ff + CAW'(1);
            end
         end else begin
            lag_in = lag_ff + LW'(1);
         end
         if (frame_end) begin
            busy_in    = 1'b0;
            in_done_in = 1'b0;
            col_in     = '0;
            in_row_in  = '0;
            lag_in     = '0;
            out_row_in = '0;
            out_col_in = '0;
         end
      end
   end

   always_comb begin
      step_in.valid  = step;
      step_in.emit   = emit;
      step_in.last   = frame_end;
      step_in.px     = pix_req ? req_pixel : '0;
      step_in.row_ok = row_ok;
      step_in.col_ok = col_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         in_done_ff    <= 1'b0;
         col_ff        <= '0;
         in_row_ff     <= '0;
         lag_ff        <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         step_ff.valid <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         in_done_ff <= in_done_in;
         col_ff     <= col_in;
         in_row_ff  <= in_row_in;
         lag_ff     <= lag_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      geo_w_ff    <= geo_w_in;
      geo_h_ff    <= geo_h_in;
      step_col_ff <= col_ff;
   end

   assign rd_en    = step;
   assign rd_addr  = col_ff;
   assign step_out = step_ff;
   assign step_col = step_col_ff;

endmodule

// ----- hw/rtl/conv5_window.sv -----
module conv5_window
   import conv5_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  step_type                      step,
   input  logic [$clog2(MAX_WIDTH)-1:0]  step_col,
   input  logic [LINE_W-1:0]             rd_data,
   output logic                          wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   output logic [LINE_W-1:0]             wr_data,
   output win_type                       win
);

   localparam int CAW = $clog2(MAX_WIDTH);

   logic [CAW-1:0]    last_addr_ff;
   logic [LINE_W-1:0] last_data_ff;
   logic              last_valid_ff;

   // window columns, oldest first; each column holds rows top to bottom
   logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_ff;
   logic             out_valid_ff;
   logic             out_last_ff;
   logic [KSIZE-1:0] out_row_ok_ff, out_col_ok_ff;

   logic [LINE_W-1:0]            above;
   logic [KSIZE-1:0][PIX_W-1:0]  vec;

   // the previous column write lands in the same cycle as this read: forward it
   assign above = (last_valid_ff && last_addr_ff == step_col) ? last_data_ff : rd_data;

   always_comb begin
      for (int r = 0; r < KSIZE - 1; r++) begin
         vec[r] = above[(KSIZE - 2 - r) * PIX_W +: PIX_W];
      end
      vec[KSIZE-1] = step.px;
   end

   assign wr_en   = step.valid;
   assign wr_addr = step_col;
   assign wr_data = {above[LINE_W-PIX_W-1:0], step.px};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (step.valid) begin
            last_valid_ff <= 1'b1;
         end
         out_valid_ff <= step.valid && step.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step.valid) begin
         last_addr_ff <= step_col;
         last_data_ff <= wr_data;
         for (int c = 0; c < KSIZE - 1; c++) begin
            win_ff[c] <= win_ff[c+1];
         end
         win_ff[KSIZE-1] <= vec;
      end
      out_last_ff   <= step.last;
      out_row_ok_ff <= step.row_ok;
      out_col_ok_ff <= step.col_ok;
   end

   always_comb begin
      win.valid  = out_valid_ff;
      win.last   = out_last_ff;
      win.row_ok = out_row_ok_ff;
      win.col_ok = out_col_ok_ff;
      for (int r = 0; r < KSIZE; r++) begin
         for (int c = 0; c < KSIZE; c++) begin
            win.px[r * KSIZE + c] = win_ff[c][r];
         end
      end
   end

endmodule

// ----- hw/rtl/conv5_mac.sv -----
module conv5_mac
   import conv5_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  win_type                     win,
   input  logic [TAPS-1:0][COEF_W-1:0] coef,
   output logic                        res_valid,
   output logic signed [SUM_W-1:0]     res_sum,
   output logic                        res_last
);

   logic signed [PROD_W-1:0] prod     [TAPS];
   logic signed [PROD_W-1:0] prod_ff  [TAPS];
   logic signed [ROW_W-1:0]  row_sum  [KSIZE];
   logic signed [ROW_W-1:0]  row_ff   [KSIZE];
   logic signed [SUM_W-1:0]  total;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     p_valid_ff, r_valid_ff, t_valid_ff;
   logic                     p_last_ff, r_last_ff, t_last_ff;

   // taps outside the frame count as zero
   always_comb begin
      for (int r = 0; r < KSIZE; r++) begin
         for (int c = 0; c < KSIZE; c++) begin
            if (win.row_ok[r] && win.col_ok[c]) begin
               prod[r * KSIZE + c] = PROD_W'($signed(coef[r * KSIZE + c]))
                                     * PROD_W'($signed({1'b0, win.px[r * KSIZE + c]}));
            end else begin
               prod[r * KSIZE + c] = '0;
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < KSIZE; r++) begin
         row_sum[r] = '0;
         for (int c = 0; c < KSIZE; c++) begin
            row_sum[r] = row_sum[r] + ROW_W'(prod_ff[r * KSIZE + c]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int r = 0; r < KSIZE; r++) begin
         total = total + SUM_W'(row_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= win.valid;
         r_valid_ff <= p_valid_ff;
         t_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod;
      row_ff    <= row_sum;
      sum_ff    <= total;
      p_last_ff <= win.last;
      r_last_ff <= p_last_ff;
      t_last_ff <= r_last_ff;
   end

   assign res_valid = t_valid_ff;
   assign res_sum   = sum_ff;
   assign res_last  = t_last_ff;

endmodule

// ----- hw/rtl/conv5_outq.sv -----
module conv5_outq
   import conv5_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic signed [SUM_W-1:0] push_sum,
   input  logic                    push_last,
   output logic                    room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SUM_W-1:0] rsp_sum,
   output logic                    rsp_last_of_frame
);

   logic [SUM_W:0]   q_ff [OUTQ_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]   count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   // room for every result that may still be in the pipe plus one more
   assign room = (count_ff <= QCW'(OUTQ_DEPTH - IN_FLIGHT));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= {push_last, push_sum};
      end
   end

   assign rsp_sum           = $signed(q_ff[rd_ptr_ff][SUM_W-1:0]);
   assign rsp_last_of_frame = q_ff[rd_ptr_ff][SUM_W];

endmodule

// ----- hw/rtl/conv5x5_zero_padded.sv -----
// Channel   Direction  Payload                         Transfer when
// req_      in         req_pixel[7:0], req_flush       req_valid & req_ready
// rsp_      out        rsp_sum[20:0] s, rsp_last_...   rsp_valid & rsp_ready
// csr_      in         csr_index[2:0], csr_wdata[63:0] csr_wr_en
//
// One item per cycle while the output queue has room: each step does one
// read-modify-write of its column in the line RAM and the 25-tap MAC tree is fully
// pipelined; a result passes the step, window, product, row-sum and total registers
// before the queue write. The first flush of a frame under 2*width+2 pixels is held
// while empty columns are stepped. Reset clears control state only, never the line RAM.
// An eight-entry output queue rides out rsp_ready stalls; req_ready drops at three held.
module conv5x5_zero_padded
   import conv5_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIX_W-1:0]        req_pixel,
   input  logic                    req_flush,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SUM_W-1:0] rsp_sum,
   output logic                    rsp_last_of_frame,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CAW = $clog2(MAX_WIDTH);

   // configuration registers
   logic [DIM_W-1:0]      frame_width_ff;
   logic [DIM_W-1:0]      frame_height_ff;
   logic [CSR_DATA_W-1:0] kernel_a_ff, kernel_b_ff, kernel_c_ff;
   logic [COEF_W-1:0]     kernel_d_ff;

   logic [TAPS-1:0][COEF_W-1:0] coef;

   logic                    room;
   logic                    rd_en;
   logic [CAW-1:0]          rd_addr;
   logic [LINE_W-1:0]       rd_data;
   logic                    wr_en;
   logic [CAW-1:0]          wr_addr;
   logic [LINE_W-1:0]       wr_data;
   step_type                step;
   logic [CAW-1:0]          step_col;
   win_type                 win;
   logic                    res_valid;
   logic signed [SUM_W-1:0] res_sum;
   logic                    res_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(1024);
         frame_height_ff <= DIM_W'(1024);
         kernel_a_ff     <= '0;
         kernel_b_ff     <= '0;
         kernel_c_ff     <= '0;
         kernel_d_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_KERNEL_A:     kernel_a_ff     <= csr_wdata;
            CSR_KERNEL_B:     kernel_b_ff     <= csr_wdata;
            CSR_KERNEL_C:     kernel_c_ff     <= csr_wdata;
            CSR_KERNEL_D:     kernel_d_ff     <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // coefficients row-major, top-left first, lowest byte of each word first
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         coef[k]      = kernel_a_ff[k * COEF_W +: COEF_W];
         coef[k + 8]  = kernel_b_ff[k * COEF_W +: COEF_W];
         coef[k + 16] = kernel_c_ff[k * COEF_W +: COEF_W];
      end
      coef[TAPS-1] = kernel_d_ff;
   end

   // position counters, drain sequencing and zero-pad masks
   conv5_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel    (req_pixel),
      .req_flush    (req_flush),
      .room         (room),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .step_out     (step),
      .step_col     (step_col)
   );

   // line store: one word per column, the four rows above the newest pixel
   conv5_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // column write-back with forwarding, 5x5 window shift
   conv5_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .step_col (step_col),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .win      (win)
   );

   // products, row sums, total
   conv5_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .coef      (coef),
      .res_valid (res_valid),
      .res_sum   (res_sum),
      .res_last  (res_last)
   );

   conv5_outq u_outq (
      .clock             (clock),
      .reset             (reset),
      .push              (res_valid),
      .push_sum          (res_sum),
      .push_last         (res_last),
      .room              (room),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sum           (rsp_sum),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
